FILE: src/differential_drive_odometry_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for differential_drive_odometry_top
// Immediate-implication and next-cycle-implication helpers, reset-gated.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, codes and constants for the wheel odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

    // Action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_ZERO   = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN    = 8'd1;

    localparam logic [15:0] PERIOD_RST = 16'd10;
    localparam logic [31:0] GAIN_RST   = 32'd3417826383;

    // Limit CORDIC gain, Q30
    localparam logic [29:0] CORDIC_K_Q30 = 30'd652032874;
    localparam int unsigned ATAN_ENTRIES = 30;
    localparam int unsigned ATAN_IDX_W   = 5;

    localparam int unsigned DEF_CORDIC_STEPS = 16;
    localparam int unsigned DEF_FRAC_BITS    = 16;

    // Shared multiplier operand widths
    localparam int unsigned MAC_A_W   = 33;
    localparam int unsigned MAC_B_W   = 16;
    localparam int unsigned MAC_ACC_W = 66;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_ROT,
        ST_SAT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic en;     // issue a partial product
        logic clear;  // start a fresh sum with this product
        logic hi;     // product weighs 2^16
    } mac_ctrl_t;

    // atan(2^-i) in binary-angle units, 2^31 = pi
    function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: src/differential_drive_odometry_top.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Wheel odometry: tracks x, y and heading of a two-wheeled robot from
// absolute wheel travel, with an iterative CORDIC and a shared multiplier.
// ----------------------------------------------------------------------------
// Wheel sample that is taken: the item passes CHECK, MUL, ROT and SAT, then
//   DONE raises out_valid; the next item is accepted once DONE returns to idle.
//   The CORDIC loop runs one step per cycle.
// Other actions and early samples: CHECK, then DONE; no new item before idle.
// in_stall is low only in idle; the output register lets one more item in.
// Reset clears pose, references, timer, primed; config back to 10, 3417826383.
`default_nettype none

`include "differential_drive_odometry_top_macros.svh"

module differential_drive_odometry_top #(
    parameter int unsigned CORDIC_STEPS = ddo_pkg::DEF_CORDIC_STEPS,
    parameter int unsigned FRAC_BITS    = ddo_pkg::DEF_FRAC_BITS
) (
    input  wire                                   clk,
    input  wire                                   rst_n,

    // input item channel
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       action,
    input  wire logic signed [31:0]               right_wheel_pos,
    input  wire logic signed [31:0]               left_wheel_pos,
    input  wire logic [31:0]                      time_ms,
    input  wire logic signed [31:0]               load_x,
    input  wire logic signed [31:0]               load_y,
    input  wire logic signed [31:0]               load_heading,

    // result item channel
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic signed [31:0]                    pose_x,
    output logic signed [31:0]                    pose_y,
    output logic signed [31:0]                    pose_heading,
    output logic                                  updated,
    output logic                                  saturated,

    // configuration write channel
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    // Step count clamps at the atan table length.
    localparam int unsigned NSTEPS = (CORDIC_STEPS > ddo_pkg::ATAN_ENTRIES) ?
                                     ddo_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int unsigned STEP_W = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEPS - 1);

    // CORDIC datapath width: |x|,|y| stay below ~2^31.1, z below ~2^31.
    localparam int unsigned CW    = 34;
    localparam int unsigned SUM_W = CW + 1;

    // Multiplier sequence: four issues, then drain until the gain product lands.
    localparam logic [2:0] MUL_K_LO  = 3'd0;
    localparam logic [2:0] MUL_K_HI  = 3'd1;
    localparam logic [2:0] MUL_G_LO  = 3'd2;
    localparam logic [2:0] MUL_G_HI  = 3'd3;
    localparam logic [2:0] MUL_K_RDY = 3'd3;  // K product in accumulator
    localparam logic [2:0] MUL_G_RDY = 3'd5;  // gain product in accumulator

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    // ---------------------------------------------------------------- state
    ddo_pkg::state_t state_reg, state_next;

    // configuration
    logic [15:0]              period_reg;
    logic [31:0]              gain_reg;

    // tracked state
    logic signed [31:0]       pos_x_reg;
    logic signed [31:0]       pos_y_reg;
    logic [31:0]              heading_reg;
    logic [31:0]              last_right_reg;
    logic [31:0]              last_left_reg;
    logic [31:0]              last_time_reg;
    logic                     primed_reg;

    // captured item
    logic [1:0]               action_reg;
    logic [31:0]              rpos_reg;
    logic [31:0]              lpos_reg;
    logic [31:0]              time_reg;
    logic [31:0]              ldx_reg;
    logic [31:0]              ldy_reg;
    logic [31:0]              ldh_reg;

    // working registers
    logic signed [31:0]       mean_reg;
    logic signed [32:0]       diff_reg;
    logic [31:0]              dang_reg;
    logic signed [CW-1:0]     cx_reg;
    logic signed [CW-1:0]     cy_reg;
    logic signed [CW-1:0]     cz_reg;
    logic [2:0]               mul_cnt_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     upd_reg;
    logic                     clip_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [31:0]       out_x_reg;
    logic signed [31:0]       out_y_reg;
    logic [31:0]              out_h_reg;
    logic                     out_upd_reg;
    logic                     out_clip_reg;

    // ------------------------------------------------------------ datapath
    logic                     in_fire;
    logic                     out_free;
    logic                     sample_ok;
    logic [31:0]              elapsed;
    logic signed [32:0]       dr_ext;
    logic signed [32:0]       dl_ext;
    logic signed [32:0]       wheel_sum;

    ddo_pkg::mac_ctrl_t                       mac_ctrl;
    logic signed [ddo_pkg::MAC_A_W-1:0]       mac_a;
    logic [ddo_pkg::MAC_B_W-1:0]              mac_b;
    logic signed [ddo_pkg::MAC_ACC_W-1:0]     mac_acc;

    logic [1:0]               quad;
    logic                     fold;
    logic signed [CW-1:0]     x_init;
    logic signed [CW-1:0]     z_init;
    logic signed [CW-1:0]     x_sh;
    logic signed [CW-1:0]     y_sh;
    logic signed [CW-1:0]     atan_ext;

    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [31:0]       sat_x;
    logic signed [31:0]       sat_y;
    logic                     clip_x;
    logic                     clip_y;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // Sample gate: wrapping elapsed time, first sample always taken.
    assign elapsed   = time_reg - last_time_reg;
    assign sample_ok = !primed_reg || (elapsed >= {16'd0, period_reg});

    // Wrap-safe wheel deltas, read as signed.
    assign dr_ext    = 33'($signed(rpos_reg - last_right_reg));
    assign dl_ext    = 33'($signed(lpos_reg - last_left_reg));
    assign wheel_sum = dr_ext + dl_ext;

    // Heading in the outer half circle: rotate by pi and negate the vector.
    assign quad     = heading_reg[31:30];
    assign fold     = quad inside {2'b01, 2'b10};
    assign x_init   = CW'($signed(mac_acc[61:30]));
    assign z_init   = CW'($signed(heading_reg ^ {fold, 31'd0}));

    // CORDIC step: floor shifts and table angle
    assign x_sh     = cx_reg >>> step_reg;
    assign y_sh     = cy_reg >>> step_reg;
    assign atan_ext = CW'(ddo_pkg::atan_entry(ddo_pkg::ATAN_IDX_W'(step_reg)));

    // Saturating pose update
    always_comb
    begin
        sum_x  = SUM_W'(pos_x_reg) + SUM_W'(cx_reg);
        sum_y  = SUM_W'(pos_y_reg) + SUM_W'(cy_reg);
        clip_x = 1'b0;
        clip_y = 1'b0;
        sat_x  = sum_x[31:0];
        sat_y  = sum_y[31:0];
        if (sum_x > SAT_MAX)
        begin
            sat_x  = 32'sh7FFFFFFF;
            clip_x = 1'b1;
        end
        else if (sum_x < SAT_MIN)
        begin
            sat_x  = 32'sh80000000;
            clip_x = 1'b1;
        end
        if (sum_y > SAT_MAX)
        begin
            sat_y  = 32'sh7FFFFFFF;
            clip_y = 1'b1;
        end
        else if (sum_y < SAT_MIN)
        begin
            sat_y  = 32'sh80000000;
            clip_y = 1'b1;
        end
    end

    // -------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ddo_pkg::ST_CHECK;
                end
            end
            ddo_pkg::ST_CHECK:
            begin
                if (action_reg == ddo_pkg::ACT_SAMPLE && sample_ok)
                begin
                    state_next = ddo_pkg::ST_MUL;
                end
                else
                begin
                    state_next = ddo_pkg::ST_DONE;
                end
            end
            ddo_pkg::ST_MUL:
            begin
                if (mul_cnt_reg == MUL_G_RDY)
                begin
                    state_next = ddo_pkg::ST_ROT;
                end
            end
            ddo_pkg::ST_ROT:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ddo_pkg::ST_SAT;
                end
            end
            ddo_pkg::ST_SAT:
            begin
                state_next = ddo_pkg::ST_DONE;
            end
            ddo_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ddo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddo_pkg::ST_IDLE;
            end
        endcase
    end

    // ----------------------------------------------------- control outputs
    always_comb
    begin
        in_stall = 1'b1;
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ddo_pkg::ST_MUL:
            begin
                case (mul_cnt_reg)
                    MUL_K_LO:
                    begin
                        mac_ctrl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
                        mac_a    = ddo_pkg::MAC_A_W'(mean_reg);
                        mac_b    = ddo_pkg::CORDIC_K_Q30[15:0];
                    end
                    MUL_K_HI:
                    begin
                        mac_ctrl = '{en: 1'b1, clear: 1'b0, hi: 1'b1};
                        mac_a    = ddo_pkg::MAC_A_W'(mean_reg);
                        mac_b    = {2'b00, ddo_pkg::CORDIC_K_Q30[29:16]};
                    end
                    MUL_G_LO:
                    begin
                        mac_ctrl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
                        mac_a    = diff_reg;
                        mac_b    = gain_reg[15:0];
                    end
                    MUL_G_HI:
                    begin
                        mac_ctrl = '{en: 1'b1, clear: 1'b0, hi: 1'b1};
                        mac_a    = diff_reg;
                        mac_b    = gain_reg[31:16];
                    end
                    default:
                    begin
                        mac_ctrl = '0;
                    end
                endcase
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    ddo_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    // ------------------------------------------------ control and pose regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ddo_pkg::ST_IDLE;
            period_reg     <= ddo_pkg::PERIOD_RST;
            gain_reg       <= ddo_pkg::GAIN_RST;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            last_right_reg <= '0;
            last_left_reg  <= '0;
            last_time_reg  <= '0;
            primed_reg     <= 1'b0;
            mul_cnt_reg    <= '0;
            step_reg       <= '0;
            upd_reg        <= 1'b0;
            clip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ddo_pkg::CFG_SAMPLE_PERIOD: period_reg <= cfg_data[15:0];
                    ddo_pkg::CFG_ANGLE_GAIN:    gain_reg   <= cfg_data;
                    default:                    ;
                endcase
            end

            case (state_reg)
                ddo_pkg::ST_CHECK:
                begin
                    mul_cnt_reg <= '0;
                    clip_reg    <= 1'b0;
                    upd_reg     <= 1'b0;
                    case (action_reg)
                        ddo_pkg::ACT_SAMPLE:
                        begin
                            upd_reg <= sample_ok;
                        end
                        ddo_pkg::ACT_LOAD:
                        begin
                            pos_x_reg   <= $signed(ldx_reg);
                            pos_y_reg   <= $signed(ldy_reg);
                            heading_reg <= ldh_reg;
                            upd_reg     <= 1'b1;
                        end
                        ddo_pkg::ACT_ZERO:
                        begin
                            last_right_reg <= '0;
                            last_left_reg  <= '0;
                            upd_reg        <= 1'b1;
                        end
                        default:
                        begin
                            upd_reg <= 1'b0;
                        end
                    endcase
                end
                ddo_pkg::ST_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg + 3'd1;
                    step_reg    <= '0;
                end
                ddo_pkg::ST_ROT:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
                ddo_pkg::ST_SAT:
                begin
                    pos_x_reg      <= sat_x;
                    pos_y_reg      <= sat_y;
                    clip_reg       <= clip_x || clip_y;
                    heading_reg    <= heading_reg + dang_reg;
                    last_right_reg <= rpos_reg;
                    last_left_reg  <= lpos_reg;
                    last_time_reg  <= time_reg;
                    primed_reg     <= 1'b1;
                end
                default:
                begin
                end
            endcase

            if (state_reg == ddo_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------- payload regs
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            action_reg <= action;
            rpos_reg   <= right_wheel_pos;
            lpos_reg   <= left_wheel_pos;
            time_reg   <= time_ms;
            ldx_reg    <= load_x;
            ldy_reg    <= load_y;
            ldh_reg    <= load_heading;
        end

        if (state_reg == ddo_pkg::ST_CHECK)
        begin
            mean_reg <= wheel_sum[32:1];   // floor of half the sum
            diff_reg <= dr_ext - dl_ext;
        end

        if (state_reg == ddo_pkg::ST_MUL && mul_cnt_reg == MUL_K_RDY)
        begin
            cx_reg <= fold ? -x_init : x_init;
            cy_reg <= '0;
            cz_reg <= z_init;
        end
        else if (state_reg == ddo_pkg::ST_ROT)
        begin
            if (!cz_reg[CW-1])
            begin
                cx_reg <= cx_reg - y_sh;
                cy_reg <= cy_reg + x_sh;
                cz_reg <= cz_reg - atan_ext;
            end
            else
            begin
                cx_reg <= cx_reg + y_sh;
                cy_reg <= cy_reg - x_sh;
                cz_reg <= cz_reg + atan_ext;
            end
        end

        if (state_reg == ddo_pkg::ST_MUL && mul_cnt_reg == MUL_G_RDY)
        begin
            dang_reg <= mac_acc[FRAC_BITS+31:FRAC_BITS];
        end

        if (state_reg == ddo_pkg::ST_DONE && out_free)
        begin
            out_x_reg    <= pos_x_reg;
            out_y_reg    <= pos_y_reg;
            out_h_reg    <= heading_reg;
            out_upd_reg  <= upd_reg;
            out_clip_reg <= clip_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pose_x       = out_x_reg;
    assign pose_y       = out_y_reg;
    assign pose_heading = $signed(out_h_reg);
    assign updated      = out_upd_reg;
    assign saturated    = out_clip_reg;

    // ---------------------------------------------------------- assertions
    `DDO_ASSERT_NEXT(a_accept_to_check, clk, rst_n, in_fire, state_reg == ddo_pkg::ST_CHECK, "accepted item did not enter check")
    `DDO_ASSERT_NEXT(a_pose_quiet, clk, rst_n, state_reg != ddo_pkg::ST_CHECK && state_reg != ddo_pkg::ST_SAT, $stable(pos_x_reg) && $stable(pos_y_reg) && $stable(heading_reg), "pose moved outside check or update")
    `DDO_ASSERT_NOW(a_step_range, clk, rst_n, state_reg == ddo_pkg::ST_ROT, step_reg <= STEP_LAST, "CORDIC step beyond table")
    `DDO_ASSERT_NEXT(a_done_holds, clk, rst_n, state_reg == ddo_pkg::ST_DONE && out_valid_reg && out_stall, state_reg == ddo_pkg::ST_DONE, "result dropped while output register busy")
    `DDO_ASSERT_NOW(a_clip_needs_update, clk, rst_n, out_valid_reg, !(out_clip_reg && !out_upd_reg), "saturated flagged without update")

endmodule

`default_nettype wire

FILE: src/ddo_mac.sv
// ----------------------------------------------------------------------------
// ddo_mac
// Shared 33x16 signed-by-unsigned multiplier with a product register and a
// 66-bit accumulator; two partial products build one 33x32 product.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_mac (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire ddo_pkg::mac_ctrl_t               ctrl,
    input  wire logic signed [ddo_pkg::MAC_A_W-1:0] a,
    input  wire logic [ddo_pkg::MAC_B_W-1:0]      b,
    output logic signed [ddo_pkg::MAC_ACC_W-1:0]  acc
);

    localparam int unsigned PROD_W = ddo_pkg::MAC_A_W + ddo_pkg::MAC_B_W + 1;

    ddo_pkg::mac_ctrl_t                     pctl_reg;
    logic signed [PROD_W-1:0]               prod_reg;
    logic signed [ddo_pkg::MAC_ACC_W-1:0]   acc_reg;
    logic signed [ddo_pkg::MAC_ACC_W-1:0]   prod_ext;
    logic signed [ddo_pkg::MAC_ACC_W-1:0]   acc_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * $signed({1'b0, b});
    end

    always_comb
    begin
        prod_ext = ddo_pkg::MAC_ACC_W'(prod_reg);
        if (pctl_reg.hi)
        begin
            prod_ext = prod_ext <<< ddo_pkg::MAC_B_W;
        end
        acc_next = (pctl_reg.clear ? '0 : acc_reg) + prod_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctl_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pctl_reg <= ctrl;
            if (pctl_reg.en)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire
